// ===== hdl/rsas_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rsas_pkg - shared types and constants for the rotated sorted array search
// Operation and status codes, controller states, and the command and status
// structs that join the controller and the datapath.
// ---------------------------------------------------------------------------
package rsas_pkg;

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 8;

    // Default store depth
    localparam int DEPTH_DEF = 256;

    // Flipping the sign bit makes unsigned order match signed order
    localparam logic [DATA_W-1:0] SIGN_FLIP = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_SEARCH = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_FOUND   = 2'd0,
        STAT_MISSING = 2'd1,
        STAT_EMPTY   = 2'd2
    } status_t;

    // Read address select for the element store
    typedef enum logic [1:0] {
        RD_MID  = 2'd0,
        RD_LAST = 2'd1,
        RD_ZERO = 2'd2
    } rd_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HI_RD,
        S_HI_WT,
        S_MIN_RD,
        S_MIN_WT,
        S_FIRST_RD,
        S_FIRST_WT,
        S_RUN_RD,
        S_RUN_WT,
        S_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic    accept;       // input word taken; clear/append done here
        rd_sel_t rd_sel;       // store read address this cycle
        logic    min_init;     // lo = 0, hi = last, hi value from read data
        logic    min_step;     // one probe of the minimum search
        logic    run_init;     // latch rotation, pick the run to search
        logic    run_step;     // one probe of the key search
        logic    set_empty;    // result: empty array
        logic    set_missing;  // result: key not found
        logic    load_out;     // move result into the output register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic op_search;   // incoming word is a search
        logic count_zero;  // no stored elements
        logic lo_lt_hi;    // search range not yet empty
        logic hit;         // probed element equals the key
        logic out_busy;    // output register full and not taken this cycle
    } dp_sts_t;

endpackage : rsas_pkg
`default_nettype wire

// ===== hdl/rsas_datapath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rsas_datapath - element store, search registers and output register
// Holds the element store and count, runs the probe updates of both binary
// searches on command, and keeps the result word until it is taken.
// ---------------------------------------------------------------------------
module rsas_datapath #(
    parameter int DEPTH = rsas_pkg::DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [rsas_pkg::OP_W-1:0]     operation,
    input  wire logic [rsas_pkg::DATA_W-1:0]   value,
    input  wire logic                          out_ready,
    input  wire rsas_pkg::dp_cmd_t             cmd,
    output rsas_pkg::dp_sts_t                  sts,
    output logic                               out_valid,
    output logic [rsas_pkg::STATUS_W-1:0]      status,
    output logic [rsas_pkg::POS_W-1:0]         position,
    output logic [rsas_pkg::POS_W-1:0]         rotation
);
    import rsas_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Element store, biased values
    logic [DATA_W-1:0] mem [DEPTH];

    logic [CW-1:0]     count_reg;
    logic [DATA_W-1:0] key_reg;
    logic [CW-1:0]     lo_reg;
    logic [CW-1:0]     hi_reg;
    logic [DATA_W-1:0] hi_val_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic [CW-1:0]     rot_reg;
    logic [CW-1:0]     pos_reg;
    status_t           res_status_reg;

    logic              out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic [POS_W-1:0]  out_rot_reg;

    logic [DATA_W-1:0] biased;
    logic [CW-1:0]     mid;
    logic [CW-1:0]     last;
    logic [AW-1:0]     rd_addr;
    logic              do_append;
    logic              key_ge_first;
    logic [CW+POS_W-1:0] pos_ext;
    logic [CW+POS_W-1:0] rot_ext;

    assign biased    = value ^ SIGN_FLIP;
    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign last      = count_reg - CW'(1);
    assign do_append = cmd.accept && (operation == OP_APPEND) && (count_reg < CW'(DEPTH));
    assign key_ge_first = (key_reg >= rdata_reg);

    // Read address select
    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_LAST: rd_addr = last[AW-1:0];
            RD_ZERO: rd_addr = '0;
            default: rd_addr = mid[AW-1:0];
        endcase
    end

    // Store write and registered read
    always_ff @(posedge clk)
    begin
        if (do_append)
        begin
            mem[count_reg[AW-1:0]] <= biased;
        end
        rdata_reg <= mem[rd_addr];
    end

    // Element count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.accept && (operation == OP_CLEAR))
        begin
            count_reg <= '0;
        end
        else if (do_append)
        begin
            count_reg <= count_reg + CW'(1);
        end
    end

    // Search registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg <= '0;
            hi_reg <= '0;
        end
        else if (cmd.min_init)
        begin
            lo_reg <= '0;
            hi_reg <= last;
        end
        else if (cmd.min_step)
        begin
            if (rdata_reg > hi_val_reg)
            begin
                lo_reg <= mid + CW'(1);
            end
            else
            begin
                hi_reg <= mid;
            end
        end
        else if (cmd.run_init)
        begin
            // lo equals hi here: that is the rotation
            if ((lo_reg != '0) && key_ge_first)
            begin
                lo_reg <= '0;
                hi_reg <= lo_reg;
            end
            else
            begin
                hi_reg <= count_reg;
            end
        end
        else if (cmd.run_step && (rdata_reg != key_reg))
        begin
            if (key_reg < rdata_reg)
            begin
                hi_reg <= mid;
            end
            else
            begin
                lo_reg <= mid + CW'(1);
            end
        end
    end

    // Payload registers of the search
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            key_reg <= biased;
            rot_reg <= '0;
            pos_reg <= '0;
        end
        if (cmd.min_init || (cmd.min_step && (rdata_reg <= hi_val_reg)))
        begin
            hi_val_reg <= rdata_reg;
        end
        if (cmd.run_init)
        begin
            rot_reg <= lo_reg;
        end
        if (cmd.run_step && (rdata_reg == key_reg))
        begin
            res_status_reg <= STAT_FOUND;
            pos_reg        <= mid;
        end
        else if (cmd.set_missing)
        begin
            res_status_reg <= STAT_MISSING;
        end
        else if (cmd.set_empty)
        begin
            res_status_reg <= STAT_EMPTY;
        end
    end

    // Output register
    assign pos_ext = {{POS_W{1'b0}}, ((res_status_reg == STAT_FOUND) ? pos_reg : CW'(0))};
    assign rot_ext = {{POS_W{1'b0}}, rot_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_pos_reg    <= pos_ext[POS_W-1:0];
            out_rot_reg    <= rot_ext[POS_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign position  = out_pos_reg;
    assign rotation  = out_rot_reg;

    // Status to the controller
    always_comb
    begin
        sts.op_search  = (operation == OP_SEARCH);
        sts.count_zero = (count_reg == '0);
        sts.lo_lt_hi   = (lo_reg < hi_reg);
        sts.hit        = (rdata_reg == key_reg);
        sts.out_busy   = out_valid_reg && !out_ready;
    end

`ifndef SYNTH
    // Count never passes the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("element count beyond depth");

    // Search range never inverts
    a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
        lo_reg <= hi_reg)
        else $error("search range inverted");

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(out_valid_reg && !out_ready))
        else $error("output word overwritten");

    // Empty result carries zero position and rotation
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == STAT_EMPTY)) |->
        (out_pos_reg == '0) && (out_rot_reg == '0))
        else $error("empty result with nonzero fields");
`endif
endmodule : rsas_datapath
`default_nettype wire

// ===== hdl/rsas_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rsas_ctrl - search sequencer
// Steps the datapath through the minimum search, the run selection and the
// key search, a read and a wait state per probe, then loads the output.
// ---------------------------------------------------------------------------
module rsas_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire rsas_pkg::dp_sts_t sts,
    output rsas_pkg::dp_cmd_t      cmd
);
    import rsas_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_MID;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.op_search)
                    begin
                        if (sts.count_zero)
                        begin
                            cmd.set_empty = 1'b1;
                            state_next    = S_DONE;
                        end
                        else
                        begin
                            state_next = S_HI_RD;
                        end
                    end
                end
            end
            S_HI_RD:
            begin
                cmd.rd_sel = RD_LAST;
                state_next = S_HI_WT;
            end
            S_HI_WT:
            begin
                cmd.min_init = 1'b1;
                state_next   = S_MIN_RD;
            end
            S_MIN_RD:
            begin
                state_next = sts.lo_lt_hi ? S_MIN_WT : S_FIRST_RD;
            end
            S_MIN_WT:
            begin
                cmd.min_step = 1'b1;
                state_next   = S_MIN_RD;
            end
            S_FIRST_RD:
            begin
                cmd.rd_sel = RD_ZERO;
                state_next = S_FIRST_WT;
            end
            S_FIRST_WT:
            begin
                cmd.run_init = 1'b1;
                state_next   = S_RUN_RD;
            end
            S_RUN_RD:
            begin
                if (sts.lo_lt_hi)
                begin
                    state_next = S_RUN_WT;
                end
                else
                begin
                    cmd.set_missing = 1'b1;
                    state_next      = S_DONE;
                end
            end
            S_RUN_WT:
            begin
                cmd.run_step = 1'b1;
                state_next   = sts.hit ? S_DONE : S_RUN_RD;
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule : rsas_ctrl
`default_nettype wire

// ===== hdl/rotated_sorted_array_search_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rotated_sorted_array_search_core - search in a rotated ascending array
// Appends signed elements after a clear; a search finds the rotation by
// binary search, then binary-searches the run that can hold the key.
// ---------------------------------------------------------------------------
//  channel | handshake            | word
//  --------+----------------------+-------------------------------------
//  in      | in_valid / in_ready  | operation, value
//  out     | out_valid / out_ready| status, position, rotation
//
//  Clear and append are done as the word is accepted. A search is paced
//  by the single read port of the element store: one read per probe. The
//  result word appears as the input reopens.
//  Reset clears the count and the output; store contents are left as is.
//  A result waiting on out_ready holds the block in its last state only
//  when a new search result is ready; clears and appends still go in.
// ---------------------------------------------------------------------------
module rotated_sorted_array_search_core #(
    parameter int DEPTH = rsas_pkg::DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [rsas_pkg::OP_W-1:0]     operation,
    input  wire logic [rsas_pkg::DATA_W-1:0]   value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [rsas_pkg::STATUS_W-1:0]      status,
    output logic [rsas_pkg::POS_W-1:0]         position,
    output logic [rsas_pkg::POS_W-1:0]         rotation
);
    import rsas_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // Sequencer
    rsas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Store and search datapath
    rsas_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .operation (operation),
        .value     (value),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .status    (status),
        .position  (position),
        .rotation  (rotation)
    );
endmodule : rotated_sorted_array_search_core
`default_nettype wire
